@@ rtl/l2tp_pkg.sv @@
// Shared types and header constants for the L2TPv2 over UDP/IPv4 encapsulator.
`timescale 1ns / 1ps
`default_nettype none
package l2tp_pkg;

    typedef enum logic [1:0] {
        MODE_ENCAP    = 2'd0,
        MODE_LOAD_SES = 2'd1,
        MODE_LOAD_TUN = 2'd2,
        MODE_FREE_SES = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_ENCAP      = 2'd0,
        ST_NO_SESSION = 2'd1,
        ST_HEADROOM   = 2'd2,
        ST_UPDATED    = 2'd3
    } t_status;

    // Work handed from the front to the back
    typedef enum logic [1:0] {
        OP_REPORT = 2'd0,
        OP_TUN_WR = 2'd1,
        OP_ENCAP  = 2'd2
    } t_op;

    typedef struct packed {
        logic [15:0] peer_id;
        logic [31:0] local_addr;
        logic [31:0] peer_addr;
        logic [31:0] port_pair;
        logic        dont_fragment;
        logic [31:0] fib;
    } t_tunnel;

    typedef struct packed {
        t_op         op;
        t_status     status;
        logic [7:0]  tunnel;
        logic [15:0] peer_sid;
        logic [15:0] frame_length;
        t_tunnel     tun;
    } t_desc;

    localparam int          HDR_BYTES      = 34;
    localparam logic [15:0] IP_LEN_ADJ     = 16'(HDR_BYTES);
    localparam logic [15:0] UDP_LEN_ADJ    = 16'(HDR_BYTES - 20);
    localparam logic [7:0]  IP_VER_IHL     = 8'h45;
    localparam logic [7:0]  IP_TTL         = 8'd64;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
    localparam logic [15:0] IP_DF_FLAGS    = 16'h4000;
    localparam logic [15:0] L2TP_FLAGS_VER = 16'h0002;
    // Fixed header words that enter the checksum: version/IHL/TOS and TTL/protocol
    localparam logic [16:0] IP_FIXED_SUM   = 17'({IP_VER_IHL, 8'h00}) +
                                             17'({IP_TTL, IP_PROTO_UDP});
    localparam logic [2:0]  LAST_BEAT      = 3'd4;
    localparam logic [3:0]  WORD_FULL      = 4'd8;
    localparam logic [3:0]  WORD_TAIL      = 4'd2;

endpackage
`default_nettype wire

@@ rtl/l2tp_ifs.sv @@
// Valid/ready channel interfaces for input items and header results.
`timescale 1ns / 1ps
`default_nettype none
interface l2tp_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [15:0]        ses_slot;
    logic [7:0]         tun_slot;
    logic [15:0]        remote_sess_id;
    logic [15:0]        remote_tun_id;
    logic [31:0]        src_ip;
    logic [31:0]        peer_ip;
    logic [31:0]        udp_ports;
    logic               df_bit;
    logic [31:0]        fib_index;
    logic [15:0]        frame_length;
    logic signed [11:0] current_offset;

    modport source (
        output valid, mode, ses_slot, tun_slot, remote_sess_id,
               remote_tun_id, src_ip, peer_ip, udp_ports, df_bit, fib_index,
               frame_length, current_offset,
        input  ready
    );
    modport sink (
        input  valid, mode, ses_slot, tun_slot, remote_sess_id,
               remote_tun_id, src_ip, peer_ip, udp_ports, df_bit, fib_index,
               frame_length, current_offset,
        output ready
    );
endinterface

interface l2tp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] header_word;
    logic [3:0]  word_bytes;
    logic [31:0] forward_table;
    logic        last;

    modport source (
        output valid, status, header_word, word_bytes, forward_table, last,
        input  ready
    );
    modport sink (
        input  valid, status, header_word, word_bytes, forward_table, last,
        output ready
    );
endinterface
`default_nettype wire

@@ rtl/l2tp_front.sv @@
// Front end: accepts transactions, owns the session table and classifies each item.
`timescale 1ns / 1ps
`default_nettype none
module l2tp_front #(
    parameter int SESSIONS = 1024,
    parameter int TUNNELS  = 256,
    parameter int PRE_DATA = 128
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    l2tp_in_if.sink           i_item,
    output logic              o_push_valid,
    output l2tp_pkg::t_desc   o_push_desc,
    input  wire               i_push_ready
);
    import l2tp_pkg::*;

    localparam int                 SIDX_W    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam logic [16:0]        SES_LIMIT = 17'(SESSIONS);
    localparam logic [8:0]         TUN_LIMIT = 9'(TUNNELS);
    localparam logic signed [12:0] HEAD_MIN  = 13'(HDR_BYTES - PRE_DATA);

    typedef enum logic [1:0] {F_CLEAR, F_IDLE, F_EVAL} t_fstate;

    typedef struct packed {
        logic [7:0]  tunnel;
        logic [15:0] peer_id;
    } t_ses;

    t_fstate            r_state;
    logic [SIDX_W-1:0]  r_clr;
    t_mode              r_mode;
    logic               r_sid_ok;
    logic               r_tun_ok;
    logic               r_head_ok;
    logic [7:0]         r_tidx;
    logic [15:0]        r_flen;
    t_tunnel            r_tun_wr;
    logic               r_valid_rd;
    t_ses               r_ses_rd;
    logic               r_valid_mem [SESSIONS];
    t_ses               r_ses_mem   [SESSIONS];

    logic               accept;
    t_mode              mode_in;
    logic [SIDX_W-1:0]  addr_in;
    logic               sid_ok_in;
    logic signed [12:0] offset_ext;
    t_desc              n_desc;

    assign i_item.ready = (r_state == F_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign mode_in      = t_mode'(i_item.mode);
    assign addr_in      = i_item.ses_slot[SIDX_W-1:0];
    assign sid_ok_in    = {1'b0, i_item.ses_slot} < SES_LIMIT;
    assign offset_ext   = {i_item.current_offset[11], i_item.current_offset};

    // Session table: valid bits cleared by a sweep after reset, data undefined
    always_ff @(posedge i_clk) begin
        if (r_state == F_CLEAR) begin
            r_valid_mem[r_clr] <= 1'b0;
        end else if (accept && sid_ok_in && mode_in == MODE_LOAD_SES) begin
            r_valid_mem[addr_in] <= 1'b1;
        end else if (accept && sid_ok_in && mode_in == MODE_FREE_SES) begin
            r_valid_mem[addr_in] <= 1'b0;
        end
        if (accept && sid_ok_in && mode_in == MODE_LOAD_SES) begin
            r_ses_mem[addr_in] <= '{tunnel: i_item.tun_slot,
                                    peer_id: i_item.remote_sess_id};
        end
        if (accept) begin
            r_valid_rd <= r_valid_mem[addr_in];
            r_ses_rd   <= r_ses_mem[addr_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_CLEAR;
            r_clr   <= '0;
        end else begin
            case (r_state)
                F_CLEAR: begin
                    if (r_clr == SIDX_W'(SESSIONS - 1)) begin
                        r_state <= F_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                F_IDLE: begin
                    if (accept) begin
                        r_mode    <= mode_in;
                        r_sid_ok  <= sid_ok_in;
                        r_tun_ok  <= {1'b0, i_item.tun_slot} < TUN_LIMIT;
                        r_head_ok <= offset_ext >= HEAD_MIN;
                        r_tidx    <= i_item.tun_slot;
                        r_flen    <= i_item.frame_length;
                        r_tun_wr  <= '{peer_id:       i_item.remote_tun_id,
                                       local_addr:    i_item.src_ip,
                                       peer_addr:     i_item.peer_ip,
                                       port_pair:     i_item.udp_ports,
                                       dont_fragment: i_item.df_bit,
                                       fib:           i_item.fib_index};
                        r_state   <= F_EVAL;
                    end
                end
                F_EVAL: begin
                    if (i_push_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    // Classify: session checks first, then headroom
    always_comb begin
        n_desc              = '0;
        n_desc.op           = OP_REPORT;
        n_desc.status       = ST_UPDATED;
        n_desc.frame_length = r_flen;
        n_desc.tun          = r_tun_wr;
        case (r_mode)
            MODE_ENCAP: begin
                if (!r_sid_ok || !r_valid_rd) begin
                    n_desc.status = ST_NO_SESSION;
                end else if ({1'b0, r_ses_rd.tunnel} >= TUN_LIMIT) begin
                    n_desc.status = ST_NO_SESSION;
                end else if (!r_head_ok) begin
                    n_desc.status = ST_HEADROOM;
                end else begin
                    n_desc.op       = OP_ENCAP;
                    n_desc.status   = ST_ENCAP;
                    n_desc.tunnel   = r_ses_rd.tunnel;
                    n_desc.peer_sid = r_ses_rd.peer_id;
                end
            end
            MODE_LOAD_SES, MODE_FREE_SES: begin
                n_desc.status = r_sid_ok ? ST_UPDATED : ST_NO_SESSION;
            end
            MODE_LOAD_TUN: begin
                if (r_tun_ok) begin
                    n_desc.op     = OP_TUN_WR;
                    n_desc.tunnel = r_tidx;
                end
            end
            default: begin
                n_desc.status = ST_UPDATED;
            end
        endcase
    end

    assign o_push_valid = (r_state == F_EVAL);
    assign o_push_desc  = n_desc;

    a_encap_needs_session: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push_valid && o_push_desc.op == OP_ENCAP) |-> (r_sid_ok && r_valid_rd))
        else $error("encapsulation pushed for an invalid session");

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_item.ready)
        else $error("input ready before the session clear sweep");

endmodule
`default_nettype wire

@@ rtl/l2tp_queue.sv @@
// Two-entry descriptor queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module l2tp_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push_valid,
    input  l2tp_pkg::t_desc   i_push_desc,
    output logic              o_push_ready,
    output logic              o_pop_valid,
    output l2tp_pkg::t_desc   o_pop_desc,
    input  wire               i_pop_ready
);
    import l2tp_pkg::*;

    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);

    t_desc              r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [PTR_W:0]     r_cnt;

    logic push;
    logic pop;

    assign o_push_ready = r_cnt != (PTR_W + 1)'(Q_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_desc   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PTR_W + 1)'(Q_DEPTH))
        else $error("descriptor queue overflow");

endmodule
`default_nettype wire

@@ rtl/l2tp_back.sv @@
// Back end: owns the tunnel table, builds the header and drives the result channel.
`timescale 1ns / 1ps
`default_nettype none
module l2tp_back #(
    parameter int TUNNELS = 256
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_q_valid,
    input  l2tp_pkg::t_desc   i_q_desc,
    output logic              o_q_ready,
    l2tp_out_if.source        o_result
);
    import l2tp_pkg::*;

    localparam int TIDX_W = (TUNNELS > 1) ? $clog2(TUNNELS) : 1;

    typedef enum logic [2:0] {B_IDLE, B_RPT, B_RD, B_SUM, B_OUT} t_bstate;

    t_bstate            r_state;
    t_desc              r_desc;
    t_tunnel            r_tun;
    t_tunnel            r_tun_mem [TUNNELS];
    logic [17:0]        r_sum1;
    logic [15:0]        r_csum;
    logic [2:0]         r_beat;
    logic               r_o_valid;
    t_status            r_o_status;
    logic [63:0]        r_o_word;
    logic [3:0]         r_o_bytes;
    logic [31:0]        r_o_fib;
    logic               r_o_last;

    logic               pop;
    logic               out_load;
    logic               out_fire;
    logic [TIDX_W-1:0]  q_addr;
    logic [15:0]        plen;
    logic [15:0]        udp_len;
    logic [15:0]        flags;
    logic [17:0]        n_sum1;
    logic [19:0]        sum2;
    logic [16:0]        fold1;
    logic [15:0]        fold2;
    logic [63:0]        n_word;

    assign o_q_ready = (r_state == B_IDLE);
    assign pop       = i_q_valid && o_q_ready;
    assign out_load  = !r_o_valid || o_result.ready;
    assign out_fire  = out_load && (r_state == B_RPT || r_state == B_OUT);
    assign q_addr    = i_q_desc.tunnel[TIDX_W-1:0];

    // Tunnel table: writes travel through the queue, so reads stay in order
    always_ff @(posedge i_clk) begin
        if (pop && i_q_desc.op == OP_TUN_WR) begin
            r_tun_mem[q_addr] <= i_q_desc.tun;
        end
        if (pop) begin
            r_tun <= r_tun_mem[q_addr];
        end
    end

    assign plen    = r_desc.frame_length + IP_LEN_ADJ;
    assign udp_len = r_desc.frame_length + UDP_LEN_ADJ;
    assign flags   = r_tun.dont_fragment ? IP_DF_FLAGS : 16'h0000;

    // Checksum in two steps: addresses first, then the rest and the fold
    assign n_sum1 = 18'(r_tun.local_addr[31:16]) + 18'(r_tun.local_addr[15:0]) +
                    18'(r_tun.peer_addr[31:16])  + 18'(r_tun.peer_addr[15:0]);
    assign sum2   = 20'(r_sum1) + 20'(plen) + 20'(flags) + 20'(IP_FIXED_SUM);
    assign fold1  = 17'(sum2[15:0]) + 17'(sum2[19:16]);
    assign fold2  = fold1[15:0] + 16'(fold1[16]);

    always_comb begin
        case (r_beat)
            3'd0:    n_word = {IP_VER_IHL, 8'h00, plen, 16'h0000, flags};
            3'd1:    n_word = {IP_TTL, IP_PROTO_UDP, r_csum, r_tun.local_addr};
            3'd2:    n_word = {r_tun.peer_addr, r_tun.port_pair};
            3'd3:    n_word = {udp_len, 16'h0000, L2TP_FLAGS_VER, r_tun.peer_id};
            3'd4:    n_word = {r_desc.peer_sid, 48'h0};
            default: n_word = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_beat    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (out_fire) begin
                r_o_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (pop) begin
                        r_desc  <= i_q_desc;
                        r_state <= (i_q_desc.op == OP_ENCAP) ? B_RD : B_RPT;
                    end
                end
                B_RPT: begin
                    if (out_load) begin
                        r_o_status <= r_desc.status;
                        r_o_word   <= '0;
                        r_o_bytes  <= '0;
                        r_o_fib    <= '0;
                        r_o_last   <= 1'b1;
                        r_state    <= B_IDLE;
                    end
                end
                B_RD: begin
                    r_sum1  <= n_sum1;
                    r_state <= B_SUM;
                end
                B_SUM: begin
                    r_csum  <= ~fold2;
                    r_beat  <= '0;
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (out_load) begin
                        r_o_status <= ST_ENCAP;
                        r_o_word   <= n_word;
                        r_o_bytes  <= (r_beat == LAST_BEAT) ? WORD_TAIL : WORD_FULL;
                        r_o_fib    <= r_tun.fib;
                        r_o_last   <= (r_beat == LAST_BEAT);
                        if (r_beat == LAST_BEAT) begin
                            r_state <= B_IDLE;
                        end else begin
                            r_beat <= r_beat + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid         = r_o_valid;
    assign o_result.status        = r_o_status;
    assign o_result.header_word   = r_o_word;
    assign o_result.word_bytes    = r_o_bytes;
    assign o_result.forward_table = r_o_fib;
    assign o_result.last          = r_o_last;

    a_report_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != ST_ENCAP) |->
            (r_o_last && r_o_bytes == '0 && r_o_word == '0 && r_o_fib == '0))
        else $error("status result carries header data");

    a_tail_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status == ST_ENCAP) |-> (r_o_last == (r_o_bytes == WORD_TAIL)))
        else $error("last flag out of step with the final header word");

    a_out_only_encap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_OUT) |-> (r_desc.op == OP_ENCAP))
        else $error("header beats for a non-encapsulation descriptor");

endmodule
`default_nettype wire

@@ rtl/l2tp_udp_ipv4_encapsulator.sv @@
// Top level of the L2TPv2 over UDP/IPv4 encapsulator.
`timescale 1ns / 1ps
`default_nettype none
// Each input transaction either updates a table or encapsulates one PPP frame.
// Mode 1 loads a session (tunnel link and peer session id), mode 2 loads a
// tunnel (addresses, UDP ports, peer tunnel id, DF flag, forwarding table),
// mode 3 frees a session, and mode 0 returns the 34-byte IPv4 + UDP + L2TPv2
// data header as five result transactions of 64 bits, first byte in bits
// 63:56, with 8, 8, 8, 8 and 2 valid bytes and last set on the fifth. The IP
// and UDP lengths follow from frame_length and the IPv4 checksum is computed
// here; the UDP checksum is zero. A missing session, a session linked to a
// tunnel beyond the table, or an offset that leaves less than 34 bytes of
// headroom ends the item with one result carrying the drop status; table
// updates answer with one result of status 3 (a session index out of range
// in modes 1 and 3 gives status 1 instead). After reset the block sweeps the
// session valid bits clear and takes no input until the sweep is done. The
// front works on one transaction at a time (accept, then session table read
// and classification) and takes the next only once it has handed its
// descriptor to a two-entry queue. The back also works on one descriptor at
// a time: a status result, or for an encapsulation the tunnel table read,
// the address sum, the rest of the checksum with its fold and the five
// header beats. The result register lets the back take the next descriptor
// and compute its checksum while a word waits. Tunnel entries must be
// written before any session that links them is encapsulated.
module l2tp_udp_ipv4_encapsulator #(
    parameter int SESSIONS = 1024,
    parameter int TUNNELS  = 256,
    parameter int PRE_DATA = 128
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    l2tp_in_if.sink     i_item,
    l2tp_out_if.source  o_result
);
    import l2tp_pkg::*;

    logic   push_valid;
    logic   push_ready;
    t_desc  push_desc;
    logic   pop_valid;
    logic   pop_ready;
    t_desc  pop_desc;

    // Classify against the session table
    l2tp_front #(
        .SESSIONS (SESSIONS),
        .TUNNELS  (TUNNELS),
        .PRE_DATA (PRE_DATA)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .o_push_valid (push_valid),
        .o_push_desc  (push_desc),
        .i_push_ready (push_ready)
    );

    // Decouple classification from header emission
    l2tp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_desc  (push_desc),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_desc   (pop_desc),
        .i_pop_ready  (pop_ready)
    );

    // Apply tunnel writes and build headers in order
    l2tp_back #(
        .TUNNELS (TUNNELS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (pop_valid),
        .i_q_desc  (pop_desc),
        .o_q_ready (pop_ready),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the L2TPv2 over UDP/IPv4 encapsulator.
`timescale 1ns / 1ps
module tb;
    import l2tp_pkg::*;

    localparam int SESSIONS    = 1024;
    localparam int TUNNELS     = 256;
    localparam int PRE_DATA    = 128;
    localparam int HDR_LEN     = 34;
    localparam int RANDOM_REQS = 237;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_OFF    = 400;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        t_mode              mode;
        logic [15:0]        sidx;
        logic [7:0]         tidx;
        logic [15:0]        peer_sid;
        logic [15:0]        peer_tid;
        logic [31:0]        src_addr;
        logic [31:0]        dst_addr;
        logic [31:0]        ports;
        logic               df;
        logic [31:0]        fib;
        logic [15:0]        frame_len;
        logic signed [11:0] offset;
    } t_req;

    typedef struct packed {
        t_status     status;
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic [31:0] fib;
        logic        last;
    } t_beat;

    // A directed row; pinned rows carry a status that is known up front
    typedef struct packed {
        t_req      req;
        logic      pinned;
        t_status   pinned_status;
    } t_dir_row;

    typedef struct packed {
        logic [15:0] peer_id;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] ports;
        logic        df;
        logic [31:0] fib;
    } t_tun_entry;

    logic clk;
    logic rst_n;

    l2tp_in_if  req_ch ();
    l2tp_out_if hdr_ch ();

    l2tp_udp_ipv4_encapsulator #(
        .SESSIONS (SESSIONS),
        .TUNNELS  (TUNNELS),
        .PRE_DATA (PRE_DATA)
    ) u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (req_ch.sink),
        .o_result (hdr_ch.source)
    );

    // Mirror of the tables inside the block
    bit            ses_valid [SESSIONS];
    logic [7:0]    ses_tunnel[SESSIONS];
    logic [15:0]   ses_peer  [SESSIONS];
    t_tun_entry    tun_tab   [TUNNELS];
    bit            tun_loaded[TUNNELS];

    t_beat     beats_due[$];
    t_dir_row  directed_reqs[$];
    int        errors = 0;
    int        cycle_count = 0;
    int        sender_calm = 0;
    int        sink_calm = 0;

    initial begin
        clk = 1'b0;
    end

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: errors");
        $finish;
    end

    // Idle count for one transaction; now and then a calm stretch with no idling
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 19);
    endfunction

    function automatic t_dir_row row(t_mode mode, logic [15:0] sidx, logic [7:0] tidx,
                                     logic [15:0] peer_sid, logic [15:0] peer_tid,
                                     logic [31:0] src, logic [31:0] dst, logic [31:0] ports,
                                     logic df, logic [31:0] fib, logic [15:0] flen, int off,
                                     logic pinned, t_status st);
        t_dir_row d;
        d.req.mode      = mode;
        d.req.sidx      = sidx;
        d.req.tidx      = tidx;
        d.req.peer_sid  = peer_sid;
        d.req.peer_tid  = peer_tid;
        d.req.src_addr  = src;
        d.req.dst_addr  = dst;
        d.req.ports     = ports;
        d.req.df        = df;
        d.req.fib       = fib;
        d.req.frame_len = flen;
        d.req.offset    = off[11:0];
        d.pinned        = pinned;
        d.pinned_status = st;
        return d;
    endfunction

    function automatic void push_single(t_status st);
        t_beat b;
        b.status = st;
        b.word   = '0;
        b.nbytes = '0;
        b.fib    = '0;
        b.last   = 1'b1;
        beats_due.push_back(b);
    endfunction

    // Update the table mirror for an accepted transaction and queue the beats it yields
    function automatic void apply_request(t_req r, logic pinned, t_status pinned_st);
        t_status       st;
        t_tun_entry    tn;
        t_beat         b;
        logic [271:0]  hdr;
        logic [15:0]   ip_len;
        logic [15:0]   flags;
        logic [31:0]   sum;
        int            off_bytes;
        int unsigned   s;
        bit            built;
        s         = r.sidx;
        off_bytes = r.offset;
        built     = 1'b0;
        st        = ST_UPDATED;
        case (r.mode)
            MODE_LOAD_SES: begin
                if (s >= SESSIONS) begin
                    st = ST_NO_SESSION;
                end else begin
                    ses_valid[s]  = 1'b1;
                    ses_tunnel[s] = r.tidx;
                    ses_peer[s]   = r.peer_sid;
                end
            end
            MODE_LOAD_TUN: begin
                if (r.tidx < TUNNELS) begin
                    tun_tab[r.tidx]    = '{r.peer_tid, r.src_addr, r.dst_addr, r.ports,
                                           r.df, r.fib};
                    tun_loaded[r.tidx] = 1'b1;
                end
            end
            MODE_FREE_SES: begin
                if (s >= SESSIONS)
                    st = ST_NO_SESSION;
                else
                    ses_valid[s] = 1'b0;
            end
            default: begin
                if (s >= SESSIONS || !ses_valid[s] || ses_tunnel[s] >= TUNNELS)
                    st = ST_NO_SESSION;
                else if (off_bytes - HDR_LEN < -PRE_DATA)
                    st = ST_HEADROOM;
                else
                    built = 1'b1;
            end
        endcase

        if (pinned) begin
            push_single(pinned_st);
        end else if (!built) begin
            push_single(st);
        end else begin
            tn     = tun_tab[ses_tunnel[s]];
            ip_len = r.frame_len + 16'd34;
            flags  = tn.df ? 16'h4000 : 16'h0000;
            // Ones'-complement sum over the IPv4 header with the checksum field zero
            sum = 32'h4500 + ip_len + flags + 32'h4011
                + tn.src_addr[31:16] + tn.src_addr[15:0]
                + tn.dst_addr[31:16] + tn.dst_addr[15:0];
            while (sum[31:16] != 16'd0)
                sum = {16'd0, sum[15:0]} + {16'd0, sum[31:16]};
            hdr = {8'h45, 8'h00, ip_len, 16'h0000, flags, 8'd64, 8'd17, ~sum[15:0],
                   tn.src_addr, tn.dst_addr, tn.ports, ip_len - 16'd20, 16'h0000,
                   16'h0002, tn.peer_id, ses_peer[s]};
            for (int i = 0; i < 5; i++) begin
                b.status = ST_ENCAP;
                b.word   = (i == 4) ? {hdr[15:0], 48'd0} : hdr[271 - 64 * i -: 64];
                b.nbytes = (i == 4) ? 4'd2 : 4'd8;
                b.fib    = tn.fib;
                b.last   = (i == 4);
                beats_due.push_back(b);
            end
        end
    endfunction

    function automatic logic [7:0] pick_tunnel();
        int unsigned v;
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom);
        v = $urandom_range(0, 7);
        return (v < 6) ? 8'(v) : 8'(248 + v);
    endfunction

    // Mostly well-formed traffic on a small pool of sessions and tunnels
    function automatic t_req build_random_req();
        t_req        r;
        int unsigned pick;
        int          o;
        r.sidx      = 16'($urandom_range(0, 11));
        pick        = $urandom_range(0, 9);
        if (pick == 0)
            r.sidx = 16'($urandom);
        else if (pick == 1)
            r.sidx = 16'($urandom_range(SESSIONS - 4, SESSIONS - 1));
        r.tidx      = pick_tunnel();
        r.peer_sid  = 16'($urandom);
        r.peer_tid  = 16'($urandom);
        r.src_addr  = $urandom;
        r.dst_addr  = $urandom;
        r.ports     = $urandom;
        r.df        = 1'($urandom_range(0, 1));
        r.fib       = $urandom;
        r.frame_len = ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                  : 16'($urandom_range(0, 1600));
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            r.offset = 12'($urandom);
        end else if (pick == 1) begin
            o        = $urandom_range(0, 1);
            r.offset = 12'(-94 - o);
        end else begin
            r.offset = 12'($urandom_range(0, 300));
        end

        pick = $urandom_range(0, 19);
        if (pick <= 10)
            r.mode = MODE_ENCAP;
        else if (pick <= 13)
            r.mode = MODE_LOAD_SES;
        else if (pick <= 16)
            r.mode = MODE_LOAD_TUN;
        else
            r.mode = MODE_FREE_SES;

        // Never encapsulate through a tunnel that was never written: load it instead
        if (r.mode == MODE_ENCAP && r.sidx < SESSIONS && ses_valid[r.sidx]
            && !tun_loaded[ses_tunnel[r.sidx]]) begin
            r.mode = MODE_LOAD_TUN;
            r.tidx = ses_tunnel[r.sidx];
        end
        return r;
    endfunction

    task automatic drive_fields(t_req r);
        req_ch.mode            <= r.mode;
        req_ch.ses_slot        <= r.sidx;
        req_ch.tun_slot        <= r.tidx;
        req_ch.remote_sess_id  <= r.peer_sid;
        req_ch.remote_tun_id   <= r.peer_tid;
        req_ch.src_ip          <= r.src_addr;
        req_ch.peer_ip         <= r.dst_addr;
        req_ch.udp_ports       <= r.ports;
        req_ch.df_bit          <= r.df;
        req_ch.fib_index       <= r.fib;
        req_ch.frame_length    <= r.frame_len;
        req_ch.current_offset  <= r.offset;
    endtask

    // Offer one transaction and return at the edge where it is taken
    task automatic offer(t_req r);
        int gap;
        gap = draw_wait(sender_calm);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        drive_fields(r);
        req_ch.valid <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off so the input backs up
    initial begin : result_sink
        int wait_cycles;
        int taken;
        taken = 0;
        hdr_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            wait_cycles = draw_wait(sink_calm);
            if (taken == 40)
                wait_cycles = HOLD_OFF;
            if (wait_cycles > 0) begin
                hdr_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            hdr_ch.ready <= 1'b1;
            @(posedge clk);
            while (!hdr_ch.valid)
                @(posedge clk);
            taken++;
        end
    end

    // Compare every accepted result with the oldest outstanding expectation
    always @(posedge clk) begin : result_check
        t_beat got;
        t_beat want;
        if (rst_n && hdr_ch.valid && hdr_ch.ready) begin
            got.status = t_status'(hdr_ch.status);
            got.word   = hdr_ch.header_word;
            got.nbytes = hdr_ch.word_bytes;
            got.fib    = hdr_ch.forward_table;
            got.last   = hdr_ch.last;
            if (beats_due.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result: status %0d word %h bytes %0d fib %h last %0b",
                             got.status, got.word, got.nbytes, got.fib, got.last);
            end else begin
                want = beats_due.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= REPORT_MAX) begin
                        $display("result mismatch at cycle %0d", cycle_count);
                        $display("  want: status %0d word %h bytes %0d fib %h last %0b",
                                 want.status, want.word, want.nbytes, want.fib, want.last);
                        $display("  got:  status %0d word %h bytes %0d fib %h last %0b",
                                 got.status, got.word, got.nbytes, got.fib, got.last);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        t_req r;
        t_req idle_req;
        idle_req = '0;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        drive_fields(idle_req);

        // Directed rows: table ops, extremes, drops and their precedence
        directed_reqs.push_back(row(MODE_ENCAP, 16'd0, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd64, 0, 1'b1, ST_NO_SESSION));
        directed_reqs.push_back(row(MODE_FREE_SES, 16'd5, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd0, 0, 1'b1, ST_UPDATED));
        directed_reqs.push_back(row(MODE_LOAD_SES, 16'd1024, 8'd3, 16'hBEEF, 16'h0, 32'h0,
            32'h0, 32'h0, 1'b0, 32'h0, 16'd0, 0, 1'b1, ST_NO_SESSION));
        directed_reqs.push_back(row(MODE_FREE_SES, 16'hFFFF, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd0, 0, 1'b1, ST_NO_SESSION));
        directed_reqs.push_back(row(MODE_LOAD_TUN, 16'd0, 8'd0, 16'h0, 16'hFFFF, 32'hFFFF_FFFF,
            32'h0, 32'hFFFF_0000, 1'b1, 32'hFFFF_FFFF, 16'd0, 0, 1'b1, ST_UPDATED));
        directed_reqs.push_back(row(MODE_LOAD_TUN, 16'd0, 8'd255, 16'h0, 16'h0, 32'h0,
            32'hFFFF_FFFF, 32'h0000_FFFF, 1'b0, 32'h0, 16'd0, 0, 1'b1, ST_UPDATED));
        directed_reqs.push_back(row(MODE_LOAD_TUN, 16'd0, 8'd7, 16'h0, 16'h1701, 32'hC0A8_0001,
            32'h0A00_0002, 32'h06A5_06A5, 1'b1, 32'd3, 16'd0, 0, 1'b1, ST_UPDATED));
        directed_reqs.push_back(row(MODE_LOAD_SES, 16'd0, 8'd0, 16'hFFFF, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd0, 0, 1'b1, ST_UPDATED));
        directed_reqs.push_back(row(MODE_LOAD_SES, 16'd1023, 8'd255, 16'h0, 16'h0, 32'h0,
            32'h0, 32'h0, 1'b0, 32'h0, 16'd0, 0, 1'b1, ST_UPDATED));
        directed_reqs.push_back(row(MODE_LOAD_SES, 16'd2, 8'd7, 16'h1234, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd0, 0, 1'b1, ST_UPDATED));
        // Empty frame, then lengths that wrap and that just fit
        directed_reqs.push_back(row(MODE_ENCAP, 16'd0, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd0, 0, 1'b0, ST_ENCAP));
        directed_reqs.push_back(row(MODE_ENCAP, 16'd1023, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'hFFFF, 0, 1'b0, ST_ENCAP));
        // Offset right at the headroom limit passes, one byte further drops
        directed_reqs.push_back(row(MODE_ENCAP, 16'd1023, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd65501, -94, 1'b0, ST_ENCAP));
        directed_reqs.push_back(row(MODE_ENCAP, 16'd2, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd100, -95, 1'b1, ST_HEADROOM));
        directed_reqs.push_back(row(MODE_ENCAP, 16'd0, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd100, -2048, 1'b1, ST_HEADROOM));
        directed_reqs.push_back(row(MODE_ENCAP, 16'd2, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd1500, 2047, 1'b0, ST_ENCAP));
        directed_reqs.push_back(row(MODE_ENCAP, 16'd1024, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd60, 0, 1'b1, ST_NO_SESSION));
        directed_reqs.push_back(row(MODE_ENCAP, 16'hFFFF, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd60, 0, 1'b1, ST_NO_SESSION));
        // Unknown session wins over a headroom drop
        directed_reqs.push_back(row(MODE_ENCAP, 16'd3, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd60, -2048, 1'b1, ST_NO_SESSION));
        directed_reqs.push_back(row(MODE_FREE_SES, 16'd2, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd0, 0, 1'b1, ST_UPDATED));
        directed_reqs.push_back(row(MODE_ENCAP, 16'd2, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd60, 0, 1'b1, ST_NO_SESSION));
        directed_reqs.push_back(row(MODE_LOAD_SES, 16'd2, 8'd0, 16'h8001, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd0, 0, 1'b1, ST_UPDATED));
        directed_reqs.push_back(row(MODE_ENCAP, 16'd2, 8'd0, 16'h0, 16'h0, 32'h0, 32'h0,
            32'h0, 1'b0, 32'h0, 16'd40, 16, 1'b0, ST_ENCAP));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // The block clears its session table first; offer() simply waits on ready
        foreach (directed_reqs[i]) begin
            offer(directed_reqs[i].req);
            apply_request(directed_reqs[i].req, directed_reqs[i].pinned,
                          directed_reqs[i].pinned_status);
        end

        for (int n = 0; n < RANDOM_REQS; n++) begin
            r = build_random_req();
            offer(r);
            apply_request(r, 1'b0, ST_ENCAP);
        end
        req_ch.valid <= 1'b0;

        // Drain, then hold a little longer to catch stray results
        while (beats_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

@@ l2tp_udp_ipv4_encapsulator.f @@
rtl/l2tp_pkg.sv
rtl/l2tp_ifs.sv
rtl/l2tp_front.sv
rtl/l2tp_queue.sv
rtl/l2tp_back.sv
rtl/l2tp_udp_ipv4_encapsulator.sv
tb/sv/tb.sv
